### sv/ctw_pkg.sv
`default_nettype none
package ctw_pkg;

	localparam int COLUMNS_DEF  = 80;
	localparam int ROWS_DEF     = 25;
	localparam int TAB_STOP_DEF = 4;

	localparam logic [15:0] CELL_CLEAR = 16'h0F00;
	localparam logic [3:0]  FG_RESET   = 4'hF;
	localparam logic [3:0]  BG_RESET   = 4'h0;

	localparam logic [7:0] CH_BS   = 8'd8;
	localparam logic [7:0] CH_TAB  = 8'd9;
	localparam logic [7:0] CH_LF   = 8'd10;
	localparam logic [7:0] CH_BSL  = 8'h5C;
	localparam logic [7:0] CH_C    = 8'h43;
	localparam logic [7:0] CH_B    = 8'h42;
	localparam logic [7:0] CH_0    = 8'h30;
	localparam logic [7:0] CH_9    = 8'h39;
	localparam logic [7:0] CH_A    = 8'h41;
	localparam logic [7:0] CH_F    = 8'h46;
	localparam logic [7:0] CH_NUL  = 8'h00;

	localparam logic [1:0] OP_STREAM = 2'd0;
	localparam logic [1:0] OP_RAW    = 2'd1;

	localparam logic [1:0] ESC_IDLE   = 2'd0;
	localparam logic [1:0] ESC_LETTER = 2'd1;
	localparam logic [1:0] ESC_DIGIT  = 2'd2;

	typedef enum logic [3:0] {
		ST_CLR,
		ST_IDLE,
		ST_RD,
		ST_RDW,
		ST_PUT,
		ST_PAINT,
		ST_FIX,
		ST_SCRL,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic [1:0] opcode;
		logic [7:0] data_byte;
		logic       last_of_write;
		logic [6:0] read_col;
		logic [4:0] read_row;
	} req_t;

	typedef struct packed {
		logic [15:0] cell_value;
		logic [6:0]  cursor_col;
		logic [4:0]  cursor_row;
		logic [3:0]  fg_now;
		logic [3:0]  bg_now;
	} rsp_t;

endpackage
`default_nettype wire

### sv/ctw_mem.sv
`default_nettype none
module ctw_mem #(
	parameter int DEPTH = ctw_pkg::COLUMNS_DEF * ctw_pkg::ROWS_DEF,
	parameter int AW    = $clog2(DEPTH)
) (
	input  wire logic          clk,
	input  wire logic          we,
	input  wire logic [AW-1:0] waddr,
	input  wire logic [15:0]   wdata,
	input  wire logic          re,
	input  wire logic [AW-1:0] raddr,
	output logic      [15:0]   rdata
);

	logic [15:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule
`default_nettype wire

### sv/text_console_writer.sv
// Text console with a COLUMNS x ROWS store of 16-bit cells (bg<<12 | fg<<8 | char).
// Every accepted transaction returns one result with the cursor and colors after
// it, and the cell for a read. After reset the block clears the cell store one
// cell a cycle, from address 0 to COLUMNS*ROWS-1, before req_ready rises.
// From the accepting cycle to the offered result: a read passes the read and
// read-wait states; a printed character passes decode, paint and wrap, and a
// cut-short escape that prints two characters passes them twice; an escape
// byte that prints nothing goes straight to the result. A line feed or wrap past
// the last row scrolls through the cell memory, one cell a cycle, before the result. One
// transaction is in work at a time; req_ready is high only while the block is idle.
`default_nettype none
module text_console_writer #(
	parameter int COLUMNS  = ctw_pkg::COLUMNS_DEF,
	parameter int ROWS     = ctw_pkg::ROWS_DEF,
	parameter int TAB_STOP = ctw_pkg::TAB_STOP_DEF
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          req_valid,
	output logic               req_ready,
	input  wire ctw_pkg::req_t req,
	output logic               rsp_valid,
	input  wire logic          rsp_ready,
	output ctw_pkg::rsp_t      rsp
);

	localparam int N      = COLUMNS * ROWS;
	localparam int NR1    = COLUMNS * (ROWS - 1);
	localparam int AW     = $clog2(N);
	localparam int SW     = $clog2(N + 1);
	localparam int XW     = $clog2(COLUMNS + TAB_STOP);
	localparam int YW     = $clog2(ROWS + 1);
	localparam int PW     = $clog2(TAB_STOP);
	localparam int PH_LAST = (COLUMNS - 1) % TAB_STOP;

	ctw_pkg::state_t state_q, state_d;

	logic [XW-1:0] x_q;
	logic [YW-1:0] y_q;
	logic [PW-1:0] ph_q;
	logic [3:0]    fg_q, bg_q;
	logic [1:0]    esc_q;
	logic          back_q;
	logic [SW-1:0] sc_q;
	logic [7:0]    ch0_q, ch1_q;
	logic          two_q;
	logic          paint_q, incx_q;
	logic [7:0]    pch_q;
	logic [AW-1:0] raddr_q;
	logic          rok_q;
	logic [15:0]   cell_q;

	logic [1:0]  p_n;
	logic [7:0]  p_c0, p_c1;
	logic [1:0]  p_esc;
	logic        p_back;
	logic [3:0]  p_fg, p_bg;
	logic        hex_ok;
	logic [3:0]  hex_v;
	logic        accept;

	logic          mem_we, mem_re;
	logic [AW-1:0] mem_waddr, mem_raddr;
	logic [15:0]   mem_wdata, mem_rdata;
	logic [AW-1:0] cur_addr;
	logic [YW-1:0] fix_y;
	logic          fix_wrap;

	assign accept    = req_valid && req_ready;
	assign req_ready = (state_q == ctw_pkg::ST_IDLE);
	assign rsp_valid = (state_q == ctw_pkg::ST_DONE);

	assign rsp.cell_value = cell_q;
	assign rsp.cursor_col = 7'(x_q);
	assign rsp.cursor_row = 5'(y_q);
	assign rsp.fg_now     = fg_q;
	assign rsp.bg_now     = bg_q;

	assign cur_addr = AW'(32'(y_q) * COLUMNS + 32'(x_q));
	assign fix_wrap = (32'(x_q) >= COLUMNS);
	assign fix_y    = fix_wrap ? YW'(y_q + 1'b1) : y_q;

	always_comb begin
		hex_ok = 1'b0;
		hex_v  = 4'd0;
		if (req.data_byte >= ctw_pkg::CH_0 && req.data_byte <= ctw_pkg::CH_9) begin
			hex_ok = 1'b1;
			hex_v  = 4'(req.data_byte - ctw_pkg::CH_0);
		end
		if (req.data_byte >= ctw_pkg::CH_A && req.data_byte <= ctw_pkg::CH_F) begin
			hex_ok = 1'b1;
			hex_v  = 4'(req.data_byte - ctw_pkg::CH_A + 8'd10);
		end
	end

	always_comb begin
		p_n    = 2'd0;
		p_c0   = req.data_byte;
		p_c1   = req.data_byte;
		p_esc  = esc_q;
		p_back = back_q;
		p_fg   = fg_q;
		p_bg   = bg_q;
		case (req.opcode)
			ctw_pkg::OP_STREAM: begin
				if (esc_q == ctw_pkg::ESC_DIGIT) begin
					p_esc = ctw_pkg::ESC_IDLE;
					if (hex_ok && back_q) begin
						p_bg = hex_v;
					end
					if (hex_ok && !back_q) begin
						p_fg = hex_v;
					end
				end else if (esc_q == ctw_pkg::ESC_LETTER &&
					(req.data_byte == ctw_pkg::CH_C || req.data_byte == ctw_pkg::CH_B)) begin
					if (req.last_of_write) begin
						p_n   = 2'd2;
						p_c0  = ctw_pkg::CH_BSL;
						p_esc = ctw_pkg::ESC_IDLE;
					end else begin
						p_esc  = ctw_pkg::ESC_DIGIT;
						p_back = (req.data_byte == ctw_pkg::CH_B);
					end
				end else if (req.data_byte == ctw_pkg::CH_BSL && !req.last_of_write) begin
					p_esc = ctw_pkg::ESC_LETTER;
					p_c0  = ctw_pkg::CH_BSL;
					p_n   = (esc_q == ctw_pkg::ESC_LETTER) ? 2'd1 : 2'd0;
				end else begin
					p_esc = ctw_pkg::ESC_IDLE;
					if (esc_q == ctw_pkg::ESC_LETTER) begin
						p_n  = 2'd2;
						p_c0 = ctw_pkg::CH_BSL;
					end else begin
						p_n = 2'd1;
					end
				end
			end
			ctw_pkg::OP_RAW: begin
				p_n = 2'd1;
			end
			default: begin
				p_n = 2'd0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ctw_pkg::ST_CLR;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		mem_we    = 1'b0;
		mem_waddr = cur_addr;
		mem_wdata = {bg_q, fg_q, pch_q};
		mem_re    = 1'b0;
		mem_raddr = raddr_q;
		case (state_q)
			ctw_pkg::ST_CLR: begin
				mem_we    = 1'b1;
				mem_waddr = AW'(sc_q);
				mem_wdata = ctw_pkg::CELL_CLEAR;
				if (32'(sc_q) == N - 1) begin
					state_d = ctw_pkg::ST_IDLE;
				end
			end
			ctw_pkg::ST_IDLE: begin
				if (accept) begin
					if (req.opcode != ctw_pkg::OP_STREAM && req.opcode != ctw_pkg::OP_RAW) begin
						state_d = ctw_pkg::ST_RD;
					end else if (p_n == 2'd0) begin
						state_d = ctw_pkg::ST_DONE;
					end else begin
						state_d = ctw_pkg::ST_PUT;
					end
				end
			end
			ctw_pkg::ST_RD: begin
				mem_re  = 1'b1;
				state_d = ctw_pkg::ST_RDW;
			end
			ctw_pkg::ST_RDW: begin
				state_d = ctw_pkg::ST_DONE;
			end
			ctw_pkg::ST_PUT: begin
				state_d = ctw_pkg::ST_PAINT;
			end
			ctw_pkg::ST_PAINT: begin
				mem_we  = paint_q;
				state_d = ctw_pkg::ST_FIX;
			end
			ctw_pkg::ST_FIX: begin
				if (32'(fix_y) >= ROWS) begin
					state_d = ctw_pkg::ST_SCRL;
				end else begin
					state_d = two_q ? ctw_pkg::ST_PUT : ctw_pkg::ST_DONE;
				end
			end
			ctw_pkg::ST_SCRL: begin
				mem_re    = (32'(sc_q) < NR1);
				mem_raddr = AW'(32'(sc_q) + COLUMNS);
				mem_we    = (sc_q != '0);
				mem_waddr = AW'(sc_q - 1'b1);
				mem_wdata = (32'(sc_q) - 1 < NR1) ? mem_rdata : 16'h0000;
				if (32'(sc_q) == N) begin
					state_d = two_q ? ctw_pkg::ST_PUT : ctw_pkg::ST_DONE;
				end
			end
			ctw_pkg::ST_DONE: begin
				if (rsp_ready) begin
					state_d = ctw_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = ctw_pkg::ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			x_q     <= '0;
			y_q     <= '0;
			ph_q    <= '0;
			fg_q    <= ctw_pkg::FG_RESET;
			bg_q    <= ctw_pkg::BG_RESET;
			esc_q   <= ctw_pkg::ESC_IDLE;
			back_q  <= 1'b0;
			sc_q    <= '0;
			two_q   <= 1'b0;
			paint_q <= 1'b0;
			incx_q  <= 1'b0;
		end else begin
			case (state_q)
				ctw_pkg::ST_CLR: begin
					sc_q <= (32'(sc_q) == N - 1) ? '0 : SW'(sc_q + 1'b1);
				end
				ctw_pkg::ST_IDLE: begin
					if (accept) begin
						esc_q  <= p_esc;
						back_q <= p_back;
						fg_q   <= p_fg;
						bg_q   <= p_bg;
						two_q  <= (p_n == 2'd2);
					end
				end
				ctw_pkg::ST_PUT: begin
					paint_q <= 1'b1;
					incx_q  <= 1'b0;
					case (ch0_q)
						ctw_pkg::CH_LF: begin
							paint_q <= 1'b0;
							x_q     <= '0;
							ph_q    <= '0;
							y_q     <= YW'(y_q + 1'b1);
						end
						ctw_pkg::CH_TAB: begin
							paint_q <= 1'b0;
							x_q     <= XW'(32'(x_q) + TAB_STOP - 32'(ph_q));
							ph_q    <= '0;
						end
						ctw_pkg::CH_BS: begin
							if (x_q != '0) begin
								x_q  <= XW'(x_q - 1'b1);
								ph_q <= (ph_q == '0) ? PW'(TAB_STOP - 1) : PW'(ph_q - 1'b1);
							end else if (y_q != '0) begin
								y_q  <= YW'(y_q - 1'b1);
								x_q  <= XW'(COLUMNS - 1);
								ph_q <= PW'(PH_LAST);
							end
						end
						default: begin
							incx_q <= 1'b1;
						end
					endcase
				end
				ctw_pkg::ST_PAINT: begin
					if (incx_q) begin
						x_q  <= XW'(x_q + 1'b1);
						ph_q <= (32'(ph_q) == TAB_STOP - 1) ? '0 : PW'(ph_q + 1'b1);
					end
				end
				ctw_pkg::ST_FIX: begin
					if (fix_wrap) begin
						x_q  <= '0;
						ph_q <= '0;
					end
					y_q   <= (32'(fix_y) >= ROWS) ? YW'(ROWS - 1) : fix_y;
					sc_q  <= '0;
					if (32'(fix_y) < ROWS && two_q) begin
						two_q <= 1'b0;
					end
				end
				ctw_pkg::ST_SCRL: begin
					if (32'(sc_q) == N) begin
						sc_q  <= '0;
						two_q <= 1'b0;
					end else begin
						sc_q <= SW'(sc_q + 1'b1);
					end
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ctw_pkg::ST_IDLE: begin
				if (accept) begin
					ch0_q   <= p_c0;
					ch1_q   <= p_c1;
					cell_q  <= 16'h0000;
					rok_q   <= (32'(req.read_col) < COLUMNS) && (32'(req.read_row) < ROWS);
					raddr_q <= AW'(32'(req.read_row) * COLUMNS + 32'(req.read_col));
				end
			end
			ctw_pkg::ST_RDW: begin
				cell_q <= rok_q ? mem_rdata : 16'h0000;
			end
			ctw_pkg::ST_PUT: begin
				pch_q <= (ch0_q == ctw_pkg::CH_BS) ? ctw_pkg::CH_NUL : ch0_q;
			end
			ctw_pkg::ST_FIX: begin
				if (32'(fix_y) < ROWS && two_q) begin
					ch0_q <= ch1_q;
				end
			end
			ctw_pkg::ST_SCRL: begin
				if (32'(sc_q) == N && two_q) begin
					ch0_q <= ch1_q;
				end
			end
			default: begin
			end
		endcase
	end

	ctw_mem #(
		.DEPTH(N),
		.AW(AW)
	) u_mem (
		.clk(clk),
		.we(mem_we),
		.waddr(mem_waddr),
		.wdata(mem_wdata),
		.re(mem_re),
		.raddr(mem_raddr),
		.rdata(mem_rdata)
	);

	assert property (@(posedge clk) disable iff (!arst_n) !(req_ready && rsp_valid))
		else $error("ready and response valid together");
	assert property (@(posedge clk) disable iff (!arst_n) req_ready |-> (32'(x_q) < COLUMNS))
		else $error("cursor column out of range while idle");
	assert property (@(posedge clk) disable iff (!arst_n) req_ready |-> (32'(y_q) < ROWS))
		else $error("cursor row out of range while idle");
	assert property (@(posedge clk) disable iff (!arst_n) (req_valid && req_ready) |=> !req_ready)
		else $error("ready stayed high after a transaction");

endmodule
`default_nettype wire

### sim/tb_top.sv
`timescale 1ns / 1ps
`default_nettype none
module tb_top;

	localparam int COLS = 80;
	localparam int NROWS = 25;
	localparam int TABW = 4;
	localparam logic [1:0] OP_READ = 2'd2;
	localparam logic [1:0] OP_SPARE = 2'd3;
	localparam int WATCHDOG_LIMIT = 60000;

	class console_scoreboard;
		logic [15:0] cells[COLS * NROWS];
		int unsigned cx, cy;
		logic [3:0] fg, bg;
		logic [1:0] esc;
		bit esc_back;
		ctw_pkg::rsp_t pending[$];
		int errors;

		function void clear();
			foreach (cells[i]) cells[i] = ctw_pkg::CELL_CLEAR;
			cx = 0; cy = 0; fg = ctw_pkg::FG_RESET; bg = ctw_pkg::BG_RESET;
			esc = ctw_pkg::ESC_IDLE; esc_back = 0; errors = 0;
			pending.delete();
		endfunction

		function void paint(logic [7:0] ch);
			cells[cy * COLS + cx] = {bg, fg, ch};
		endfunction

		function void put_char(logic [7:0] ch);
			case (ch)
				ctw_pkg::CH_LF: begin
					cx = 0; cy++;
				end
				ctw_pkg::CH_TAB: begin
					cx++;
					while (cx % TABW != 0) cx++;
				end
				ctw_pkg::CH_BS: begin
					if (cx > 0) cx--;
					else if (cy > 0) begin
						cy--; cx = COLS - 1;
					end
					paint(ctw_pkg::CH_NUL);
				end
				default: begin
					paint(ch); cx++;
				end
			endcase
			if (cx >= COLS) begin
				cx = 0; cy++;
			end
			if (cy >= NROWS) begin
				for (int i = 0; i < COLS * (NROWS - 1); i++) cells[i] = cells[i + COLS];
				for (int i = COLS * (NROWS - 1); i < COLS * NROWS; i++) cells[i] = '0;
				cy = NROWS - 1;
			end
		endfunction

		function void stream_byte(logic [7:0] b, bit last);
			if (esc == ctw_pkg::ESC_DIGIT) begin
				if (b >= ctw_pkg::CH_0 && b <= ctw_pkg::CH_9) begin
					if (esc_back) bg = 4'(b - ctw_pkg::CH_0);
					else fg = 4'(b - ctw_pkg::CH_0);
				end else if (b >= ctw_pkg::CH_A && b <= ctw_pkg::CH_F) begin
					if (esc_back) bg = 4'(b - ctw_pkg::CH_A + 8'd10);
					else fg = 4'(b - ctw_pkg::CH_A + 8'd10);
				end
				esc = ctw_pkg::ESC_IDLE;
				return;
			end
			if (esc == ctw_pkg::ESC_LETTER) begin
				if (b == ctw_pkg::CH_C || b == ctw_pkg::CH_B) begin
					if (last) begin
						put_char(ctw_pkg::CH_BSL); put_char(b); esc = ctw_pkg::ESC_IDLE;
					end else begin
						esc = ctw_pkg::ESC_DIGIT; esc_back = (b == ctw_pkg::CH_B);
					end
					return;
				end
				put_char(ctw_pkg::CH_BSL);
			end
			esc = ctw_pkg::ESC_IDLE;
			if (b == ctw_pkg::CH_BSL && !last) esc = ctw_pkg::ESC_LETTER;
			else put_char(b);
		endfunction

		function void note_request(ctw_pkg::req_t r);
			ctw_pkg::rsp_t e;
			e.cell_value = '0;
			if (r.opcode == ctw_pkg::OP_STREAM) stream_byte(r.data_byte, r.last_of_write);
			else if (r.opcode == ctw_pkg::OP_RAW) put_char(r.data_byte);
			else if (r.read_col < COLS && r.read_row < NROWS)
				e.cell_value = cells[r.read_row * COLS + r.read_col];
			e.cursor_col = 7'(cx); e.cursor_row = 5'(cy); e.fg_now = fg; e.bg_now = bg;
			pending.push_back(e);
		endfunction

		function void check_response(ctw_pkg::rsp_t a);
			ctw_pkg::rsp_t e;
			if (pending.size() == 0) begin
				$error("unexpected result %h", a);
				errors++;
				return;
			end
			e = pending.pop_front();
			if (a.cell_value !== e.cell_value) begin
				$error("cell_value exp %h got %h", e.cell_value, a.cell_value); errors++;
			end
			if (a.cursor_col !== e.cursor_col) begin
				$error("cursor_col exp %0d got %0d", e.cursor_col, a.cursor_col); errors++;
			end
			if (a.cursor_row !== e.cursor_row) begin
				$error("cursor_row exp %0d got %0d", e.cursor_row, a.cursor_row); errors++;
			end
			if (a.fg_now !== e.fg_now) begin
				$error("fg_now exp %h got %h", e.fg_now, a.fg_now); errors++;
			end
			if (a.bg_now !== e.bg_now) begin
				$error("bg_now exp %h got %h", e.bg_now, a.bg_now); errors++;
			end
		endfunction
	endclass

	logic clk = 0;
	logic arst_n = 0;
	logic req_valid = 0;
	logic req_ready;
	ctw_pkg::req_t req = '0;
	logic rsp_valid;
	logic rsp_ready = 0;
	ctw_pkg::rsp_t rsp;

	console_scoreboard board = new();
	bit quiet_tail = 0;
	bit hold_sink = 0;
	int idle_cycles = 0;
	int sent = 0;

	always #1 clk = ~clk;

	text_console_writer dut (
		.clk(clk), .arst_n(arst_n),
		.req_valid(req_valid), .req_ready(req_ready), .req(req),
		.rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp(rsp)
	);

	always @(posedge clk) begin
		if (req_valid && req_ready) board.note_request(req);
		if (rsp_valid && rsp_ready) board.check_response(rsp);
		if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || !arst_n)
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("Simulation FAILED");
			$finish;
		end
	end

	always begin
		@(negedge clk);
		if (hold_sink) rsp_ready <= 0;
		else if (!quiet_tail && $urandom_range(0, 5) == 0) begin
			rsp_ready <= 0;
			repeat ($urandom_range(1, 4)) @(negedge clk);
			rsp_ready <= 1;
		end else rsp_ready <= 1;
	end

	task automatic send(logic [1:0] op, logic [7:0] b, bit last,
			logic [6:0] col = 7'd0, logic [4:0] row = 5'd0);
		if (!quiet_tail && $urandom_range(0, 5) == 0) begin
			req_valid <= 0;
			repeat ($urandom_range(1, 4)) @(negedge clk);
		end
		req_valid <= 1;
		req <= '{opcode: op, data_byte: b, last_of_write: last, read_col: col, read_row: row};
		do @(posedge clk); while (!req_ready);
		@(negedge clk);
		sent++;
	endtask

	task automatic read_cell(logic [6:0] col, logic [4:0] row);
		send(OP_READ, 8'($urandom), 1'($urandom), col, row);
	endtask

	task automatic drain();
		req_valid <= 0;
		@(negedge clk);
		while (board.pending.size() != 0) @(negedge clk);
	endtask

	function automatic logic [7:0] pick_byte();
		case ($urandom_range(0, 9))
			0: return ctw_pkg::CH_LF;
			1: return ctw_pkg::CH_TAB;
			2: return ctw_pkg::CH_BS;
			3: return ctw_pkg::CH_BSL;
			default: return 8'($urandom);
		endcase
	endfunction

	task automatic escape_seq();
		logic [7:0] digits[16] = '{"0","1","2","3","4","5","6","7","8","9",
			"A","B","C","D","E","F"};
		send(ctw_pkg::OP_STREAM, ctw_pkg::CH_BSL, 0);
		send(ctw_pkg::OP_STREAM, $urandom_range(0, 1) ? ctw_pkg::CH_C : ctw_pkg::CH_B, 0);
		send(ctw_pkg::OP_STREAM, $urandom_range(0, 7) ? digits[$urandom_range(0, 15)] :
			8'($urandom), $urandom_range(0, 3) == 0);
	endtask

	initial begin
		board.clear();
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1;

		send(ctw_pkg::OP_STREAM, ctw_pkg::CH_BS, 1);
		read_cell(0, 0);
		send(ctw_pkg::OP_STREAM, 8'hFF, 0);
		send(ctw_pkg::OP_RAW, 8'h00, 1);
		send(ctw_pkg::OP_STREAM, ctw_pkg::CH_BSL, 0);
		send(ctw_pkg::OP_STREAM, ctw_pkg::CH_C, 0);
		send(ctw_pkg::OP_STREAM, "A", 1);
		send(ctw_pkg::OP_STREAM, ctw_pkg::CH_BSL, 0);
		send(ctw_pkg::OP_STREAM, ctw_pkg::CH_B, 0);
		send(ctw_pkg::OP_STREAM, "9", 0);
		send(ctw_pkg::OP_STREAM, ctw_pkg::CH_BSL, 0);
		send(ctw_pkg::OP_STREAM, "x", 0);
		send(ctw_pkg::OP_STREAM, ctw_pkg::CH_BSL, 0);
		send(ctw_pkg::OP_STREAM, ctw_pkg::CH_C, 1);
		send(ctw_pkg::OP_STREAM, ctw_pkg::CH_BSL, 1);
		send(ctw_pkg::OP_STREAM, ctw_pkg::CH_BSL, 0);
		send(ctw_pkg::OP_RAW, ctw_pkg::CH_BSL, 0);
		send(ctw_pkg::OP_STREAM, ctw_pkg::CH_B, 0);
		send(ctw_pkg::OP_STREAM, "g", 0);
		send(ctw_pkg::OP_STREAM, ctw_pkg::CH_TAB, 0);
		read_cell(79, 24);
		read_cell(80, 0);
		read_cell(127, 31);
		send(OP_SPARE, 8'h55, 1, 1, 0);
		send(ctw_pkg::OP_STREAM, ctw_pkg::CH_LF, 1);

		drain();
		hold_sink = 1;
		fork
			begin
				repeat (300) @(negedge clk);
				hold_sink = 0;
			end
			repeat (6) send(ctw_pkg::OP_RAW, 8'($urandom), 0);
		join
		drain();

		while (sent < 1350) begin
			if (sent > 1150) quiet_tail = 1;
			if (sent == 700) drain();
			case ($urandom_range(0, 9))
				0, 1: escape_seq();
				2, 3: read_cell($urandom_range(0, 7) ? 7'($urandom_range(0, 79)) : 7'($urandom),
					$urandom_range(0, 7) ? 5'($urandom_range(0, 24)) : 5'($urandom));
				4: send(ctw_pkg::OP_RAW, pick_byte(), 1'($urandom));
				5: send(2'($urandom), 8'($urandom), 1'($urandom), 7'($urandom), 5'($urandom));
				default: send(ctw_pkg::OP_STREAM, pick_byte(), $urandom_range(0, 3) == 0);
			endcase
		end

		drain();
		repeat (20) @(negedge clk);
		if (board.errors == 0 && board.pending.size() == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end
endmodule
`default_nettype wire

### filelist.f
sv/ctw_pkg.sv
sv/ctw_mem.sv
sv/text_console_writer.sv
sim/tb_top.sv
